// ----- rtl/hnf_pkg.sv -----
// ----------------------------------------------------------------------------
// hnf_pkg
// shared types and constants for the annex b nal unit fragmenter
// ----------------------------------------------------------------------------
package hnf_pkg;

    // frame size limit and its position counter width (holds limit + 1)
    localparam int unsigned MAX_FRAME_BYTES = 32'd16777216;
    localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1) + 1;
    localparam int unsigned OFF_W           = 24;
    localparam int unsigned LEN_W           = 25;

    // start codes accepted per frame
    localparam int unsigned MAX_FRAGMENTS   = 32;
    localparam int unsigned CNT_W           = $clog2(MAX_FRAGMENTS + 1);

    // result queue
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // codec mode codes
    localparam logic MODE_H264 = 1'b0;
    localparam logic MODE_VP8  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_CODE  = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             last;
        status_t          status;
    } frag_result_t;

endpackage

// ----- rtl/h264_nalu_fragmenter_top.sv -----
// ----------------------------------------------------------------------------
// h264_nalu_fragmenter_top
// splits an annex b byte stream frame into (offset, length) fragment items
// ----------------------------------------------------------------------------
// usage
//   s_axis carries the frame one byte per item, tlast on the final byte.
//   m_axis carries fragment items: tdata = offset then length, tlast marks
//   the closing item of a frame, tuser = status (ok, no start code, too long).
//   cfg_we / cfg_wdata write codec_mode (0 h.264 start-code split, 1 vp8
//   single fragment); write it only between frames.
// throughput
//   one byte per cycle while s_axis_tready is high. the start-code window,
//   the confirm compare and the fragment arithmetic all settle in the cycle
//   a byte is accepted, and the results are written into a four-entry
//   result queue at that edge, from which m_axis reads them in order.
//   a byte yields at most two items (a confirmed fragment plus the closing
//   item), so s_axis_tready is high while the queue has two free entries.
// reset and stall
//   rst_n clears the frame state, the queue and selects h.264 mode.
//   when m_axis_tready is low the queue holds its items; input keeps flowing
//   until fewer than two queue entries are free.
// ----------------------------------------------------------------------------
module h264_nalu_fragmenter_top
    import hnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // fragment items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [23:0] fragment_offset, [48:24] fragment_length
    output logic        m_axis_tlast,   // last_fragment
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_wdata       // codec_mode
);

    // ------------------------------------------------------------------------
    // frame state
    // ------------------------------------------------------------------------
    logic             mode_reg;
    logic [31:0]      win_reg,        win_next;
    logic [POS_W-1:0] pos_reg,        pos_next;
    logic [CNT_W-1:0] cnt_reg,        cnt_next;
    logic [OFF_W-1:0] start_reg,      start_next;
    logic             open_reg,       open_next;
    logic [OFF_W-1:0] pend_pos_reg,   pend_pos_next;
    logic [2:0]       pend_len_reg,   pend_len_next;
    logic             pend_valid_reg, pend_valid_next;

    // result queue
    frag_result_t      queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] qcnt_reg,   qcnt_next;

    logic in_fire;
    logic out_fire;

    // scan datapath
    logic             overflow;
    logic             scan;
    logic             confirm;
    logic             emit_mid;
    logic [OFF_W-1:0] start_a;
    logic             open_a;
    logic [CNT_W-1:0] cnt_a;
    logic             search;
    logic             four;
    logic             three;
    logic [POS_W-1:0] pos_inc;

    frag_result_t mid_res;
    frag_result_t close_res;

    logic [QPTR_W-1:0] close_ptr;
    logic [QCNT_W-1:0] push_cnt;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // room for the worst case of two items per byte
    assign s_axis_tready = (qcnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        win_next = {win_reg[23:0], s_axis_tdata};
        overflow = (pos_reg >= POS_W'(MAX_FRAME_BYTES));
        scan     = !overflow && (mode_reg == MODE_H264);

        // a pending code is kept once the byte four places past its start arrives
        confirm  = scan && pend_valid_reg &&
                   (pos_reg >= (POS_W'(pend_pos_reg) + POS_W'(4)));
        emit_mid = confirm && open_reg;

        start_a  = confirm ? (pend_pos_reg + OFF_W'(pend_len_reg)) : start_reg;
        open_a   = open_reg || confirm;
        cnt_a    = cnt_reg + CNT_W'(confirm);

        search   = scan && !(pend_valid_reg && !confirm) &&
                   (cnt_a < CNT_W'(MAX_FRAGMENTS));
        // the four-byte code wins over the three-byte code inside it
        four     = (win_next == 32'h0000_0001) &&
                   (pos_reg >= (POS_W'(start_a) + POS_W'(3)));
        three    = (win_next[23:0] == 24'h00_0001) &&
                   (pos_reg >= (POS_W'(start_a) + POS_W'(2)));

        pend_pos_next   = pend_pos_reg;
        pend_len_next   = pend_len_reg;
        pend_valid_next = pend_valid_reg && !confirm;
        if (search && four)
        begin
            pend_pos_next   = pos_reg[OFF_W-1:0] - OFF_W'(3);
            pend_len_next   = 3'd4;
            pend_valid_next = 1'b1;
        end
        else if (search && three)
        begin
            pend_pos_next   = pos_reg[OFF_W-1:0] - OFF_W'(2);
            pend_len_next   = 3'd3;
            pend_valid_next = 1'b1;
        end

        // past the limit the position parks at limit + 1
        pos_inc = overflow ? POS_W'(MAX_FRAME_BYTES + 1) : (pos_reg + POS_W'(1));

        mid_res.offset = start_reg;
        mid_res.length = LEN_W'(pend_pos_reg - start_reg);
        mid_res.last   = 1'b0;
        mid_res.status = STATUS_OK;

        close_res.last = 1'b1;
        if (pos_inc > POS_W'(MAX_FRAME_BYTES))
        begin
            close_res.offset = '0;
            close_res.length = '0;
            close_res.status = STATUS_TOO_LONG;
        end
        else if (mode_reg == MODE_VP8)
        begin
            close_res.offset = '0;
            close_res.length = LEN_W'(pos_inc);
            close_res.status = STATUS_OK;
        end
        else if (!open_a)
        begin
            close_res.offset = '0;
            close_res.length = '0;
            close_res.status = STATUS_NO_CODE;
        end
        else
        begin
            close_res.offset = start_a;
            close_res.length = LEN_W'(pos_inc - POS_W'(start_a));
            close_res.status = STATUS_OK;
        end

        // every frame starts clean after its final byte
        if (s_axis_tlast)
        begin
            win_next        = '0;
            pos_next        = '0;
            cnt_next        = '0;
            start_next      = '0;
            open_next       = 1'b0;
            pend_pos_next   = '0;
            pend_len_next   = '0;
            pend_valid_next = 1'b0;
        end
        else
        begin
            pos_next   = pos_inc;
            cnt_next   = cnt_a;
            start_next = start_a;
            open_next  = open_a;
        end
    end

    // queue pointers
    always_comb
    begin
        close_ptr   = wr_ptr_reg + QPTR_W'(emit_mid);
        push_cnt    = in_fire ? (QCNT_W'(emit_mid) + QCNT_W'(s_axis_tlast)) : '0;
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(out_fire);
        qcnt_next   = qcnt_reg + push_cnt - QCNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_H264;
            win_reg        <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            start_reg      <= '0;
            open_reg       <= 1'b0;
            pend_pos_reg   <= '0;
            pend_len_reg   <= '0;
            pend_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            qcnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                win_reg        <= win_next;
                pos_reg        <= pos_next;
                cnt_reg        <= cnt_next;
                start_reg      <= start_next;
                open_reg       <= open_next;
                pend_pos_reg   <= pend_pos_next;
                pend_len_reg   <= pend_len_next;
                pend_valid_reg <= pend_valid_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            qcnt_reg   <= qcnt_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire && emit_mid)
        begin
            queue_reg[wr_ptr_reg] <= mid_res;
        end
        if (in_fire && s_axis_tlast)
        begin
            queue_reg[close_ptr] <= close_res;
        end
    end

    // output side
    assign m_axis_tvalid = (qcnt_reg != '0);
    assign m_axis_tdata  = {7'd0, queue_reg[rd_ptr_reg].length,
                            queue_reg[rd_ptr_reg].offset};
    assign m_axis_tlast  = queue_reg[rd_ptr_reg].last;
    assign m_axis_tuser  = queue_reg[rd_ptr_reg].status;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // a final byte always leaves a closing item in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> m_axis_tvalid)
        else $error("no item after final byte");

    // frame state is clean after a final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=>
            (pos_reg == '0 && !open_reg && !pend_valid_reg && cnt_reg == '0))
        else $error("frame state not cleared");

    // fragment count stays within the code limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_FRAGMENTS))
        else $error("fragment count past limit");

endmodule
